// ===== rtl/assert_macros.svh =====
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RLPT_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("rlpt assertion failed");

// property whose consequent must hold in the cycle after the antecedent
`define RLPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlpt assertion failed");

`endif

// ===== rtl/rlpt_pkg.sv =====
// shared types, constants and helpers of the rms line protection trip block
package rlpt_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int ADC_BITS   = 12;
   localparam int ROOT_W     = 12;
   localparam int SQ_W       = 2 * ROOT_W;
   localparam int TILT_W     = 11;
   localparam int DEB_W      = 4;
   localparam int CSR_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int DEFAULT_MAX_WINDOW = 512;

   localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);
   localparam logic [DEB_W-1:0]    STREAK_MAX = 4'd15;

   typedef logic [1:0] cause_type;
   localparam cause_type CAUSE_NONE  = 2'd0;
   localparam cause_type CAUSE_SHORT = 2'd1;
   localparam cause_type CAUSE_TILT  = 2'd2;
   localparam cause_type CAUSE_OVERV = 2'd3;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type REG_VOLTAGE_OFFSET = 3'd0;
   localparam csr_index_type REG_CURRENT_OFFSET = 3'd1;
   localparam csr_index_type REG_VOLTAGE_HIGH   = 3'd2;
   localparam csr_index_type REG_VOLTAGE_LOW    = 3'd3;
   localparam csr_index_type REG_CURRENT_LIMIT  = 3'd4;
   localparam csr_index_type REG_TILT_LIMIT     = 3'd5;
   localparam csr_index_type REG_DEBOUNCE       = 3'd6;

   localparam logic [SAMPLE_W-1:0] RST_VOLTAGE_OFFSET = 12'd2048;
   localparam logic [SAMPLE_W-1:0] RST_CURRENT_OFFSET = 12'd2048;
   localparam logic [SAMPLE_W-1:0] RST_VOLTAGE_HIGH   = 12'd2904;
   localparam logic [SAMPLE_W-1:0] RST_VOLTAGE_LOW    = 12'd2010;
   localparam logic [SAMPLE_W-1:0] RST_CURRENT_LIMIT  = 12'd1861;
   localparam logic [TILT_W-1:0]   RST_TILT_LIMIT     = 11'd250;
   localparam logic [DEB_W-1:0]    RST_DEBOUNCE       = 4'd3;

   // handshake between the sequencer and the root unit
   typedef struct packed {
      logic busy;
      logic done;
   } root_status_type;

   function automatic logic [DEB_W-1:0] streak_next(input logic [DEB_W-1:0] streak,
                                                    input logic bad);
      logic [DEB_W-1:0] result;
      if (!bad) begin
         result = '0;
      end else if (streak < STREAK_MAX) begin
         result = streak + 1'b1;
      end else begin
         result = STREAK_MAX;
      end
      return result;
   endfunction

endpackage

// ===== rtl/rms_line_protection_trip.sv =====
// top level: sample accumulation, rms evaluation and trip latch of the line protection block
//
// req_ channel takes one paired voltage/current sample word with window_end and tilt_delta.
// every word is centered and squared through one shared multiplier (voltage, then current)
// and added to the window sums; req_ready is low after each accepted word until idle again.
// a word with window_end set closes the window: the shared root unit divides each sum by
// the sample count (one quotient bit a cycle) and takes the floor root (two bits a cycle),
// first voltage then current, on a SUM_W = 24 + clog2(MAX_WINDOW + 1) bit sum, then a
// decision state checks the limits and the debounce streaks.
// that word then produces one rsp_ word; other words produce none.
// the rsp_ word sits in an output register; a stalled receiver only holds the decision state
// of the next closing window, and no word is taken while it waits; until then words are taken.
// samples beyond MAX_WINDOW in one window are dropped from the sums. reset (synchronous)
// restores the limit registers, clears sums, streaks and the trip latch; a latched trip
// holds until reset. the user makes csr_ writes only while idle, unchecked by the block.
module rms_line_protection_trip #(
   parameter int MAX_WINDOW = rlpt_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rlpt_pkg::SAMPLE_W-1:0]         req_voltage_sample,
   input  logic [rlpt_pkg::SAMPLE_W-1:0]         req_current_sample,
   input  logic                                  req_window_end,
   input  logic [rlpt_pkg::TILT_W-1:0]           req_tilt_delta,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rlpt_pkg::ROOT_W-1:0]           rsp_voltage_rms,
   output logic [rlpt_pkg::ROOT_W-1:0]           rsp_current_rms,
   output logic                                  rsp_relay_closed,
   output logic                                  rsp_is_tripped,
   output logic [1:0]                            rsp_trip_cause,
   output logic                                  rsp_undervoltage,
   input  logic                                  csr_we,
   input  logic [rlpt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rlpt_pkg::CSR_W-1:0]            csr_wdata
);

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = rlpt_pkg::SQ_W + CNT_W;
   localparam int SW    = rlpt_pkg::SAMPLE_W;
   localparam int RW    = rlpt_pkg::ROOT_W;
   localparam int DW    = rlpt_pkg::DEB_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQ_V   = 3'd1;
   localparam logic [2:0] S_SQ_I   = 3'd2;
   localparam logic [2:0] S_ADD_I  = 3'd3;
   localparam logic [2:0] S_ROOT_V = 3'd4;
   localparam logic [2:0] S_ROOT_I = 3'd5;
   localparam logic [2:0] S_JUDGE  = 3'd6;

   logic [2:0]  state_ff, state_in;

   logic [SW-1:0]               voffs_ff, ioffs_ff, vhigh_ff, vlow_ff, ilim_ff;
   logic [rlpt_pkg::TILT_W-1:0] tlim_ff;
   logic [DW-1:0]               deb_ff;

   logic [SUM_W-1:0]            vsum_ff, vsum_in, isum_ff, isum_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [SW-1:0]               vs_ff, vs_in, cs_ff, cs_in;
   logic                        last_ff, last_in, take_ff, take_in;
   logic [rlpt_pkg::TILT_W-1:0] tilt_ff, tilt_in;
   logic [rlpt_pkg::SQ_W-1:0]   prod_ff, prod_in;
   logic [RW-1:0]               vrms_ff, vrms_in, crms_ff, crms_in;
   logic [DW-1:0]               vstreak_ff, vstreak_in, istreak_ff, istreak_in;
   logic [DW-1:0]               tstreak_ff, tstreak_in;
   logic                        fault_ff, fault_in;
   rlpt_pkg::cause_type         cause_ff, cause_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]               rsp_vrms_ff, rsp_vrms_in, rsp_crms_ff, rsp_crms_in;
   logic                        rsp_closed_ff, rsp_closed_in, rsp_trip_ff, rsp_trip_in;
   rlpt_pkg::cause_type         rsp_cause_ff, rsp_cause_in;
   logic                        rsp_under_ff, rsp_under_in;

   logic [SW-1:0]               sq_sample, sq_offset, sq_diff;
   logic [rlpt_pkg::SQ_W-1:0]   sq_ext;
   logic [SUM_W-1:0]            root_dividend;
   logic                        root_start;
   rlpt_pkg::root_status_type   root_status;
   logic [RW-1:0]               root_value;

   logic [DW-1:0]               need;
   logic [DW-1:0]               vs_next, is_next, ts_next;

   // shared centering multiplier
   always_comb begin
      sq_sample = (state_ff == S_SQ_V) ? vs_ff : cs_ff;
      sq_offset = (state_ff == S_SQ_V) ? voffs_ff : ioffs_ff;
      sq_diff   = (sq_sample >= sq_offset) ? (sq_sample - sq_offset)
                                           : (sq_offset - sq_sample);
      sq_ext    = rlpt_pkg::SQ_W'(sq_diff);
   end

   rlpt_root #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .dividend (root_dividend),
      .divisor  (count_ff),
      .status   (root_status),
      .root     (root_value)
   );

   always_comb begin
      need    = (deb_ff == '0) ? DW'(1) : deb_ff;
      ts_next = rlpt_pkg::streak_next(tstreak_ff, tilt_ff > tlim_ff);
      vs_next = rlpt_pkg::streak_next(vstreak_ff, vrms_ff > vhigh_ff);
      is_next = rlpt_pkg::streak_next(istreak_ff, crms_ff > ilim_ff);
   end

   always_comb begin
      state_in      = state_ff;
      vsum_in       = vsum_ff;
      isum_in       = isum_ff;
      count_in      = count_ff;
      vs_in         = vs_ff;
      cs_in         = cs_ff;
      last_in       = last_ff;
      take_in       = take_ff;
      tilt_in       = tilt_ff;
      prod_in       = prod_ff;
      vrms_in       = vrms_ff;
      crms_in       = crms_ff;
      vstreak_in    = vstreak_ff;
      istreak_in    = istreak_ff;
      tstreak_in    = tstreak_ff;
      fault_in      = fault_ff;
      cause_in      = cause_ff;
      rsp_vrms_in   = rsp_vrms_ff;
      rsp_crms_in   = rsp_crms_ff;
      rsp_closed_in = rsp_closed_ff;
      rsp_trip_in   = rsp_trip_ff;
      rsp_cause_in  = rsp_cause_ff;
      rsp_under_in  = rsp_under_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      root_start    = 1'b0;
      root_dividend = vsum_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               vs_in   = req_voltage_sample & rlpt_pkg::ADC_MASK;
               cs_in   = req_current_sample & rlpt_pkg::ADC_MASK;
               last_in = req_window_end;
               tilt_in = req_tilt_delta;
               // window full: drop the word from the sums
               take_in = (count_ff < CNT_W'(MAX_WINDOW));
               if (count_ff < CNT_W'(MAX_WINDOW)) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = S_SQ_V;
            end
         end
         S_SQ_V: begin
            prod_in  = sq_ext * sq_ext;
            state_in = S_SQ_I;
         end
         S_SQ_I: begin
            if (take_ff) begin
               vsum_in = vsum_ff + SUM_W'(prod_ff);
            end
            prod_in  = sq_ext * sq_ext;
            state_in = S_ADD_I;
         end
         S_ADD_I: begin
            if (take_ff) begin
               isum_in = isum_ff + SUM_W'(prod_ff);
            end
            if (last_ff) begin
               root_start    = 1'b1;
               root_dividend = vsum_ff;
               state_in      = S_ROOT_V;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ROOT_V: begin
            if (root_status.done) begin
               vrms_in       = root_value;
               root_start    = 1'b1;
               root_dividend = isum_ff;
               state_in      = S_ROOT_I;
            end
         end
         S_ROOT_I: begin
            if (root_status.done) begin
               crms_in  = root_value;
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_under_in = 1'b0;
               if (!fault_ff) begin
                  tstreak_in = ts_next;
                  vstreak_in = vs_next;
                  istreak_in = is_next;
                  if (is_next >= need) begin
                     cause_in = rlpt_pkg::CAUSE_SHORT;
                     fault_in = 1'b1;
                  end else if (ts_next >= need) begin
                     cause_in = rlpt_pkg::CAUSE_TILT;
                     fault_in = 1'b1;
                  end else if (vs_next >= need) begin
                     cause_in = rlpt_pkg::CAUSE_OVERV;
                     fault_in = 1'b1;
                  end else begin
                     rsp_under_in = (vrms_ff < vlow_ff);
                  end
               end
               rsp_vrms_in   = vrms_ff;
               rsp_crms_in   = crms_ff;
               rsp_closed_in = !fault_in;
               rsp_trip_in   = fault_in;
               rsp_cause_in  = cause_in;
               rsp_valid_in  = 1'b1;
               vsum_in       = '0;
               isum_in       = '0;
               count_in      = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vsum_ff      <= '0;
         isum_ff      <= '0;
         count_ff     <= '0;
         vstreak_ff   <= '0;
         istreak_ff   <= '0;
         tstreak_ff   <= '0;
         fault_ff     <= 1'b0;
         cause_ff     <= rlpt_pkg::CAUSE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vsum_ff      <= vsum_in;
         isum_ff      <= isum_in;
         count_ff     <= count_in;
         vstreak_ff   <= vstreak_in;
         istreak_ff   <= istreak_in;
         tstreak_ff   <= tstreak_in;
         fault_ff     <= fault_in;
         cause_ff     <= cause_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vs_ff         <= vs_in;
      cs_ff         <= cs_in;
      last_ff       <= last_in;
      take_ff       <= take_in;
      tilt_ff       <= tilt_in;
      prod_ff       <= prod_in;
      vrms_ff       <= vrms_in;
      crms_ff       <= crms_in;
      rsp_vrms_ff   <= rsp_vrms_in;
      rsp_crms_ff   <= rsp_crms_in;
      rsp_closed_ff <= rsp_closed_in;
      rsp_trip_ff   <= rsp_trip_in;
      rsp_cause_ff  <= rsp_cause_in;
      rsp_under_ff  <= rsp_under_in;
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         voffs_ff <= rlpt_pkg::RST_VOLTAGE_OFFSET;
         ioffs_ff <= rlpt_pkg::RST_CURRENT_OFFSET;
         vhigh_ff <= rlpt_pkg::RST_VOLTAGE_HIGH;
         vlow_ff  <= rlpt_pkg::RST_VOLTAGE_LOW;
         ilim_ff  <= rlpt_pkg::RST_CURRENT_LIMIT;
         tlim_ff  <= rlpt_pkg::RST_TILT_LIMIT;
         deb_ff   <= rlpt_pkg::RST_DEBOUNCE;
      end else if (csr_we) begin
         case (csr_index)
            rlpt_pkg::REG_VOLTAGE_OFFSET: voffs_ff <= csr_wdata;
            rlpt_pkg::REG_CURRENT_OFFSET: ioffs_ff <= csr_wdata;
            rlpt_pkg::REG_VOLTAGE_HIGH:   vhigh_ff <= csr_wdata;
            rlpt_pkg::REG_VOLTAGE_LOW:    vlow_ff  <= csr_wdata;
            rlpt_pkg::REG_CURRENT_LIMIT:  ilim_ff  <= csr_wdata;
            rlpt_pkg::REG_TILT_LIMIT:     tlim_ff  <= csr_wdata[rlpt_pkg::TILT_W-1:0];
            rlpt_pkg::REG_DEBOUNCE:       deb_ff   <= csr_wdata[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voltage_rms  = rsp_vrms_ff;
   assign rsp_current_rms  = rsp_crms_ff;
   assign rsp_relay_closed = rsp_closed_ff;
   assign rsp_is_tripped   = rsp_trip_ff;
   assign rsp_trip_cause   = rsp_cause_ff;
   assign rsp_undervoltage = rsp_under_ff;

   `RLPT_ASSERT_NEXT(a_trip_holds, fault_ff, fault_ff)
   `RLPT_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_WINDOW))
   `RLPT_ASSERT(a_trip_has_cause, !rsp_valid_ff || (rsp_trip_ff == (rsp_cause_ff != rlpt_pkg::CAUSE_NONE)))
   `RLPT_ASSERT(a_root_idle_when_ready, !(req_ready && root_status.busy))
   `RLPT_ASSERT(a_under_only_untripped, !(rsp_valid_ff && rsp_under_ff && rsp_trip_ff))

endmodule

// ===== rtl/rlpt_root.sv =====
// iterative unit: floor(dividend / divisor) one bit a cycle, then floor square root
module rlpt_root #(
   parameter int MAX_WINDOW = rlpt_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [rlpt_pkg::SQ_W+$clog2(MAX_WINDOW+1)-1:0] dividend,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]        divisor,
   output rlpt_pkg::root_status_type              status,
   output logic [rlpt_pkg::ROOT_W-1:0]            root
);

   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = rlpt_pkg::SQ_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int RW     = rlpt_pkg::ROOT_W;
   localparam int SREM_W = RW + 3;

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_DIV  = 2'd1;
   localparam logic [1:0] R_SQRT = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  drem_ff, drem_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [SREM_W-1:0] srem_ff, srem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    drem_sh;
   logic              qbit;
   logic [SREM_W-1:0] srem_sh;
   logic [SREM_W-1:0] trial;
   logic              sbit;

   always_comb begin
      drem_sh = {drem_ff, dvd_ff[SUM_W-1]};
      qbit    = (drem_sh >= {1'b0, divisor_ff});
      srem_sh = {srem_ff[RW:0], dvd_ff[rlpt_pkg::SQ_W-1 -: 2]};
      trial   = SREM_W'({root_ff, 2'b01});
      sbit    = (srem_sh >= trial);
   end

   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      dvd_in     = dvd_ff;
      drem_in    = drem_ff;
      divisor_in = divisor_ff;
      srem_in    = srem_ff;
      root_in    = root_ff;
      done_in    = 1'b0;
      case (phase_ff)
         R_IDLE: begin
            if (start) begin
               phase_in   = R_DIV;
               step_in    = STEP_W'(SUM_W - 1);
               dvd_in     = dividend;
               divisor_in = divisor;
               drem_in    = '0;
            end
         end
         R_DIV: begin
            // restoring division, quotient bits shift in behind the dividend
            drem_in = qbit ? CNT_W'(drem_sh - {1'b0, divisor_ff}) : drem_sh[CNT_W-1:0];
            dvd_in  = {dvd_ff[SUM_W-2:0], qbit};
            if (step_ff == '0) begin
               phase_in = R_SQRT;
               step_in  = STEP_W'(RW - 1);
               srem_in  = '0;
               root_in  = '0;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         R_SQRT: begin
            // mean square fits in SQ_W bits, take two bits per step
            srem_in = sbit ? (srem_sh - trial) : srem_sh;
            root_in = {root_ff[RW-2:0], sbit};
            dvd_in  = {dvd_ff[SUM_W-3:0], 2'b00};
            if (step_ff == '0) begin
               phase_in = R_IDLE;
               done_in  = 1'b1;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: begin
            phase_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      step_ff    <= step_in;
      dvd_ff     <= dvd_in;
      drem_ff    <= drem_in;
      divisor_ff <= divisor_in;
      srem_ff    <= srem_in;
      root_ff    <= root_in;
   end

   assign status.busy = (phase_ff != R_IDLE);
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

// ===== tb/rlpt_checker.sv =====
// checker for the rms line protection trip block: predicts each rms report and compares
module rlpt_checker
   import rlpt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [SAMPLE_W-1:0]  req_voltage_sample,
   input  logic [SAMPLE_W-1:0]  req_current_sample,
   input  logic                 req_window_end,
   input  logic [TILT_W-1:0]    req_tilt_delta,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [ROOT_W-1:0]    rsp_voltage_rms,
   input  logic [ROOT_W-1:0]    rsp_current_rms,
   input  logic                 rsp_relay_closed,
   input  logic                 rsp_is_tripped,
   input  logic [1:0]           rsp_trip_cause,
   input  logic                 rsp_undervoltage,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count,
   output int                   report_count
);

   localparam int WINDOW_CAP = DEFAULT_MAX_WINDOW;

   typedef struct packed {
      logic [ROOT_W-1:0] voltage_rms;
      logic [ROOT_W-1:0] current_rms;
      logic              relay_closed;
      logic              is_tripped;
      cause_type         trip_cause;
      logic              undervoltage;
   } line_report_type;

   // shadow copy of the limit registers
   logic [SAMPLE_W-1:0] v_off, c_off, v_high, v_low, c_lim;
   logic [TILT_W-1:0]   t_lim;
   logic [DEB_W-1:0]    deb;

   // window sums and trip state
   logic [32:0]         v_acc, c_acc;
   logic [9:0]          n_acc;
   logic [DEB_W-1:0]    v_run, c_run, t_run;
   logic                tripped;
   cause_type           cause;

   line_report_type     predicted_reports[$];
   int                  errors = 0;
   int                  reports = 0;

   assign mismatch_count = errors;
   assign report_count   = reports;

   function automatic logic [32:0] dev_square(input logic [SAMPLE_W-1:0] s,
                                              input logic [SAMPLE_W-1:0] off);
      logic [32:0] d;
      d = (s >= off) ? 33'(s - off) : 33'(off - s);
      return d * d;
   endfunction

   // bitwise search, the root of a mean square always fits in ROOT_W bits
   function automatic logic [ROOT_W-1:0] floor_root(input logic [32:0] x);
      logic [ROOT_W-1:0] r, cand;
      logic [32:0]       wide;
      r = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         cand = r | (ROOT_W'(1) << b);
         wide = 33'(cand);
         if (wide * wide <= x) r = cand;
      end
      return r;
   endfunction

   function automatic logic [DEB_W-1:0] next_run(input logic [DEB_W-1:0] run, input logic bad);
      if (!bad) return '0;
      return (run == '1) ? run : run + 1'b1;
   endfunction

   task automatic absorb_word();
      logic [SAMPLE_W-1:0] vs, cs;
      logic [ROOT_W-1:0]   v_rms, c_rms;
      logic [DEB_W-1:0]    need;
      logic                fresh_trip, low;
      line_report_type     rep;
      vs = req_voltage_sample & ADC_MASK;
      cs = req_current_sample & ADC_MASK;
      // words beyond the window capacity leave the sums alone
      if (n_acc < WINDOW_CAP) begin
         v_acc = v_acc + dev_square(vs, v_off);
         c_acc = c_acc + dev_square(cs, c_off);
         n_acc = n_acc + 1'b1;
      end
      if (req_window_end) begin
         if (n_acc != '0) begin
            v_rms = floor_root(v_acc / n_acc);
            c_rms = floor_root(c_acc / n_acc);
         end else begin
            v_rms = '0;
            c_rms = '0;
         end
         v_acc = '0;
         c_acc = '0;
         n_acc = '0;
         fresh_trip = 1'b0;
         low = 1'b0;
         if (!tripped) begin
            need = (deb == '0) ? DEB_W'(1) : deb;
            t_run = next_run(t_run, req_tilt_delta > t_lim);
            v_run = next_run(v_run, v_rms > v_high);
            c_run = next_run(c_run, c_rms > c_lim);
            if (c_run >= need) begin
               cause = CAUSE_SHORT;
               fresh_trip = 1'b1;
            end else if (t_run >= need) begin
               cause = CAUSE_TILT;
               fresh_trip = 1'b1;
            end else if (v_run >= need) begin
               cause = CAUSE_OVERV;
               fresh_trip = 1'b1;
            end else if (v_rms < v_low) begin
               low = 1'b1;
            end
            if (fresh_trip) tripped = 1'b1;
         end
         rep.voltage_rms  = v_rms;
         rep.current_rms  = c_rms;
         rep.relay_closed = !tripped;
         rep.is_tripped   = tripped;
         rep.trip_cause   = cause;
         rep.undervoltage = low;
         predicted_reports.push_back(rep);
      end
   endtask

   task automatic compare_report();
      line_report_type want;
      if (predicted_reports.size() == 0) begin
         if (errors < 10)
            $display("unexpected rsp word: v=%0d c=%0d relay=%0b trip=%0b cause=%0d uv=%0b",
                     rsp_voltage_rms, rsp_current_rms, rsp_relay_closed, rsp_is_tripped,
                     rsp_trip_cause, rsp_undervoltage);
         errors++;
      end else begin
         want = predicted_reports.pop_front();
         if (want.voltage_rms !== rsp_voltage_rms || want.current_rms !== rsp_current_rms ||
             want.relay_closed !== rsp_relay_closed || want.is_tripped !== rsp_is_tripped ||
             want.trip_cause !== rsp_trip_cause || want.undervoltage !== rsp_undervoltage) begin
            if (errors < 10) begin
               $display("rsp word %0d expected: v=%0d c=%0d relay=%0b trip=%0b cause=%0d uv=%0b",
                        reports, want.voltage_rms, want.current_rms, want.relay_closed,
                        want.is_tripped, want.trip_cause, want.undervoltage);
               $display("rsp word %0d actual:   v=%0d c=%0d relay=%0b trip=%0b cause=%0d uv=%0b",
                        reports, rsp_voltage_rms, rsp_current_rms, rsp_relay_closed,
                        rsp_is_tripped, rsp_trip_cause, rsp_undervoltage);
            end
            errors++;
         end
         reports++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         v_off   = RST_VOLTAGE_OFFSET;
         c_off   = RST_CURRENT_OFFSET;
         v_high  = RST_VOLTAGE_HIGH;
         v_low   = RST_VOLTAGE_LOW;
         c_lim   = RST_CURRENT_LIMIT;
         t_lim   = RST_TILT_LIMIT;
         deb     = RST_DEBOUNCE;
         v_acc   = '0;
         c_acc   = '0;
         n_acc   = '0;
         v_run   = '0;
         c_run   = '0;
         t_run   = '0;
         tripped = 1'b0;
         cause   = CAUSE_NONE;
         predicted_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_report();
         if (csr_we) begin
            case (csr_index)
               REG_VOLTAGE_OFFSET: v_off = csr_wdata;
               REG_CURRENT_OFFSET: c_off = csr_wdata;
               REG_VOLTAGE_HIGH:   v_high = csr_wdata;
               REG_VOLTAGE_LOW:    v_low = csr_wdata;
               REG_CURRENT_LIMIT:  c_lim = csr_wdata;
               REG_TILT_LIMIT:     t_lim = csr_wdata[TILT_W-1:0];
               REG_DEBOUNCE:       deb = csr_wdata[DEB_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) absorb_word();
      end
      pending_count <= predicted_reports.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// top of the testbench: clock, reset, sample stimulus, register settings and verdict
module tb_top;
   import rlpt_pkg::*;

   localparam int WINDOW_CAP      = DEFAULT_MAX_WINDOW;
   localparam int LATENCY_WAIT    = 200;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_voltage_sample = '0;
   logic [SAMPLE_W-1:0] req_current_sample = '0;
   logic                req_window_end = 1'b0;
   logic [TILT_W-1:0]   req_tilt_delta = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ROOT_W-1:0]   rsp_voltage_rms, rsp_current_rms;
   logic                rsp_relay_closed, rsp_is_tripped;
   logic [1:0]          rsp_trip_cause;
   logic                rsp_undervoltage;
   logic                csr_we = 1'b0;
   csr_index_type       csr_index = REG_VOLTAGE_OFFSET;
   logic [CSR_W-1:0]    csr_wdata = '0;

   int                  mismatch_count, pending_count, report_count;
   int                  words_sent = 0;
   int                  settings_loaded = 0;
   int                  quiet_cycles = 0;
   bit                  idling_on = 1'b1;
   bit                  hold_rsp = 1'b0;

   // register values the stimulus is shaped around
   logic [CSR_W-1:0]    cfg [REG_VOLTAGE_OFFSET:REG_DEBOUNCE];

   always #10 clock = ~clock;

   rms_line_protection_trip i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_voltage_sample (req_voltage_sample),
      .req_current_sample (req_current_sample),
      .req_window_end     (req_window_end),
      .req_tilt_delta     (req_tilt_delta),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_voltage_rms    (rsp_voltage_rms),
      .rsp_current_rms    (rsp_current_rms),
      .rsp_relay_closed   (rsp_relay_closed),
      .rsp_is_tripped     (rsp_is_tripped),
      .rsp_trip_cause     (rsp_trip_cause),
      .rsp_undervoltage   (rsp_undervoltage),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   rlpt_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_voltage_sample (req_voltage_sample),
      .req_current_sample (req_current_sample),
      .req_window_end     (req_window_end),
      .req_tilt_delta     (req_tilt_delta),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_voltage_rms    (rsp_voltage_rms),
      .rsp_current_rms    (rsp_current_rms),
      .rsp_relay_closed   (rsp_relay_closed),
      .rsp_is_tripped     (rsp_is_tripped),
      .rsp_trip_cause     (rsp_trip_cause),
      .rsp_undervoltage   (rsp_undervoltage),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .report_count       (report_count)
   );

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // receiver: short random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            hold_rsp = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] c,
                            input logic last, input logic [TILT_W-1:0] tilt);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_voltage_sample <= v;
      req_current_sample <= c;
      req_window_end     <= last;
      req_tilt_delta     <= tilt;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      words_sent++;
   endtask

   // sample at roughly mag counts from the offset, sign random where both fit
   function automatic logic [SAMPLE_W-1:0] shaped_sample(input int off, input int mag);
      int m, s;
      m = mag - ((mag >= 8) ? int'($urandom_range(0, mag / 8)) : 0);
      if (off + m > 4095) s = off - m;
      else if (off - m < 0) s = off + m;
      else s = ($urandom_range(0, 1) != 0) ? off + m : off - m;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      return SAMPLE_W'(s);
   endfunction

   function automatic int pick_level(input int limit, input bit bad);
      int lvl;
      if (!bad) lvl = $urandom_range(0, limit);
      else lvl = limit + 1 + limit / 7 + int'($urandom_range(0, 200));
      return (lvl > 4095) ? 4095 : lvl;
   endfunction

   function automatic logic [TILT_W-1:0] pick_tilt(input int limit, input bit bad);
      if (!bad) return TILT_W'($urandom_range(0, limit));
      return (limit >= 1800) ? TILT_W'(1800) : TILT_W'($urandom_range(limit + 1, 1800));
   endfunction

   task automatic send_window(input int len, input int vmag, input int cmag,
                              input logic [TILT_W-1:0] tilt_end, input bit noise);
      logic [SAMPLE_W-1:0] v, c;
      logic                last;
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         if (noise) begin
            v = SAMPLE_W'($urandom_range(0, 4095));
            c = SAMPLE_W'($urandom_range(0, 4095));
         end else begin
            v = shaped_sample(int'(cfg[REG_VOLTAGE_OFFSET]), vmag);
            c = shaped_sample(int'(cfg[REG_CURRENT_OFFSET]), cmag);
         end
         // tilt only counts on the closing word
         send_word(v, c, last, last ? tilt_end : TILT_W'($urandom_range(0, 1800)));
      end
   endtask

   task automatic random_window(input int bad_pct);
      int len, pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 4);
      else if (pick < 9) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 48);
      send_window(len,
                  pick_level(int'(cfg[REG_VOLTAGE_HIGH]), $urandom_range(0, 99) < bad_pct),
                  pick_level(int'(cfg[REG_CURRENT_LIMIT]), $urandom_range(0, 99) < bad_pct),
                  pick_tilt(int'(cfg[REG_TILT_LIMIT]), $urandom_range(0, 99) < bad_pct),
                  $urandom_range(0, 9) == 0);
   endtask

   task automatic run_phase(input int budget, input int bad_pct);
      int start;
      start = words_sent;
      while (words_sent - start < budget) random_window(bad_pct);
   endtask

   // drain every report, then let the root unit finish before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic load_settings();
      for (int i = REG_VOLTAGE_OFFSET; i <= REG_DEBOUNCE; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= cfg[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   task automatic randomize_settings();
      cfg[REG_VOLTAGE_OFFSET] = CSR_W'($urandom_range(1500, 2600));
      cfg[REG_CURRENT_OFFSET] = CSR_W'($urandom_range(1500, 2600));
      cfg[REG_VOLTAGE_HIGH]   = CSR_W'($urandom_range(300, 2000));
      cfg[REG_VOLTAGE_LOW]    = CSR_W'($urandom_range(0, cfg[REG_VOLTAGE_HIGH]));
      cfg[REG_CURRENT_LIMIT]  = CSR_W'($urandom_range(300, 2000));
      cfg[REG_TILT_LIMIT]     = CSR_W'($urandom_range(0, 1800));
      cfg[REG_DEBOUNCE]       = CSR_W'($urandom_range(6, 15));
   endtask

   initial begin
      cfg[REG_VOLTAGE_OFFSET] = RST_VOLTAGE_OFFSET;
      cfg[REG_CURRENT_OFFSET] = RST_CURRENT_OFFSET;
      cfg[REG_VOLTAGE_HIGH]   = RST_VOLTAGE_HIGH;
      cfg[REG_VOLTAGE_LOW]    = RST_VOLTAGE_LOW;
      cfg[REG_CURRENT_LIMIT]  = RST_CURRENT_LIMIT;
      cfg[REG_TILT_LIMIT]     = CSR_W'(RST_TILT_LIMIT);
      cfg[REG_DEBOUNCE]       = CSR_W'(RST_DEBOUNCE);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset settings
      send_word(12'd0, 12'd4095, 1'b1, 11'd0);
      send_word(12'd4095, 12'd0, 1'b1, 11'd1800);
      send_word(12'd2048, 12'd2048, 1'b1, 11'd250);
      // rms just under the low limit, current exactly at its limit, tilt inside ignored
      send_word(12'd4057, 12'd3909, 1'b0, 11'd1800);
      send_word(12'd4057, 12'd3909, 1'b0, 11'd1800);
      send_word(12'd4057, 12'd3909, 1'b1, 11'd251);
      send_word(12'd4058, 12'd186, 1'b1, 11'd0);
      send_word(12'd0, 12'd2048, 1'b0, 11'd0);
      send_word(12'd4095, 12'd2048, 1'b1, 11'd0);
      // mean square that needs flooring
      send_word(12'd2051, 12'd2047, 1'b0, 11'd0);
      send_word(12'd2044, 12'd2050, 1'b0, 11'd0);
      send_word(12'd2048, 12'd2048, 1'b0, 11'd0);
      send_word(12'd2049, 12'd2045, 1'b1, 11'd0);
      send_word(12'hAAA, 12'h555, 1'b1, 11'h555);
      send_word(12'h555, 12'hAAA, 1'b1, 11'h2AA);
      settle();

      // extreme offsets and limits that cannot trip
      cfg[REG_VOLTAGE_OFFSET] = 12'd0;
      cfg[REG_CURRENT_OFFSET] = 12'd4095;
      cfg[REG_VOLTAGE_HIGH]   = 12'd4095;
      cfg[REG_VOLTAGE_LOW]    = 12'd0;
      cfg[REG_CURRENT_LIMIT]  = 12'd4095;
      cfg[REG_TILT_LIMIT]     = 12'd1800;
      cfg[REG_DEBOUNCE]       = 12'd15;
      load_settings();
      run_phase(110, 15);
      // full-scale window running past its capacity
      send_window(WINDOW_CAP + 3, 4095, 4095, 11'd0, 1'b0);
      settle();

      cfg[REG_VOLTAGE_OFFSET] = 12'd4095;
      cfg[REG_CURRENT_OFFSET] = 12'd0;
      cfg[REG_VOLTAGE_HIGH]   = CSR_W'($urandom_range(300, 2000));
      cfg[REG_VOLTAGE_LOW]    = 12'd4095;
      cfg[REG_CURRENT_LIMIT]  = CSR_W'($urandom_range(300, 2000));
      cfg[REG_TILT_LIMIT]     = 12'd0;
      cfg[REG_DEBOUNCE]       = 12'd15;
      load_settings();
      hold_rsp = 1'b1;
      run_phase(110, 15);
      settle();

      repeat (3) begin
         randomize_settings();
         load_settings();
         run_phase(110, 15);
         settle();
      end

      // last part: no idling, settings that make a trip likely, then tripped reports
      idling_on = 1'b0;
      cfg[REG_VOLTAGE_OFFSET] = CSR_W'($urandom_range(1500, 2600));
      cfg[REG_CURRENT_OFFSET] = CSR_W'($urandom_range(1500, 2600));
      cfg[REG_VOLTAGE_HIGH]   = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(200, 1500));
      cfg[REG_VOLTAGE_LOW]    = CSR_W'($urandom_range(0, 4095));
      cfg[REG_CURRENT_LIMIT]  = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(200, 1500));
      cfg[REG_TILT_LIMIT]     = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(0, 1000));
      case ($urandom_range(0, 3))
         0: cfg[REG_DEBOUNCE] = 12'd0;
         1: cfg[REG_DEBOUNCE] = 12'd1;
         2: cfg[REG_DEBOUNCE] = 12'd15;
         default: cfg[REG_DEBOUNCE] = CSR_W'($urandom_range(2, 5));
      endcase
      load_settings();
      run_phase(150, 90);
      settle();

      $display("covered %0d sample words and %0d rms reports over %0d register settings",
               words_sent, report_count, settings_loaded + 1);
      $display("with a full-scale window past capacity, a %0d-cycle receiver hold-off and a trip phase",
               RSP_HOLD_CYCLES);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== rms_line_protection_trip.f =====
+incdir+rtl
rtl/rlpt_pkg.sv
rtl/rlpt_root.sv
rtl/rms_line_protection_trip.sv
tb/rlpt_checker.sv
tb/tb_top.sv
